@@ src/cfir_pkg.sv @@
`timescale 1ns / 1ps

package cfir_pkg;

   localparam int TAPS        = 25;
   localparam int SAMPLE_BITS = 16;
   localparam int RESULT_BITS = 26;

   // index into the delay line memory and tap counter
   localparam int IDX_BITS   = (TAPS > 1) ? $clog2(TAPS) : 1;
   // fill count has to reach TAPS itself
   localparam int CNT_BITS   = $clog2(TAPS + 1);
   // tap coefficients run 1..TAPS, unsigned
   localparam int COEF_BITS  = $clog2(TAPS + 1);
   // signed sample times signed-extended coefficient
   localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS + 1;
   localparam int WORD_BITS  = 2 * SAMPLE_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear;
      logic vld;
      logic live;
      logic last;
   } mac_ctl_type;

endpackage

@@ src/cfir_mac.sv @@
`timescale 1ns / 1ps

module cfir_mac (
   input  logic                                     clock,
   input  logic                                     reset,
   input  cfir_pkg::mac_ctl_type                    ctl,
   input  logic [cfir_pkg::IDX_BITS-1:0]            tap,
   input  logic signed [cfir_pkg::SAMPLE_BITS-1:0]  hist_real,
   input  logic signed [cfir_pkg::SAMPLE_BITS-1:0]  hist_imag,
   output logic signed [cfir_pkg::RESULT_BITS-1:0]  acc_real,
   output logic signed [cfir_pkg::RESULT_BITS-1:0]  acc_imag,
   output logic                                     done
);

   logic [cfir_pkg::COEF_BITS-1:0]         coef_re;
   logic [cfir_pkg::COEF_BITS-1:0]         coef_im;
   logic signed [cfir_pkg::SAMPLE_BITS-1:0] x_re;
   logic signed [cfir_pkg::SAMPLE_BITS-1:0] x_im;
   logic signed [cfir_pkg::COEF_BITS:0]    c_re;
   logic signed [cfir_pkg::COEF_BITS:0]    c_im;

   logic signed [cfir_pkg::PROD_BITS-1:0]  p_rr_in, p_ii_in, p_ri_in, p_ir_in;
   logic signed [cfir_pkg::PROD_BITS-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic                                   p_vld_ff, p_last_ff;
   logic signed [cfir_pkg::RESULT_BITS-1:0] acc_real_in, acc_imag_in;
   logic signed [cfir_pkg::RESULT_BITS-1:0] acc_real_ff, acc_imag_ff;
   logic                                   done_ff;

   // tap k: real coefficient k+1, imaginary coefficient TAPS-k
   always_comb begin
      coef_re = cfir_pkg::COEF_BITS'(tap) + cfir_pkg::COEF_BITS'(1);
      coef_im = cfir_pkg::COEF_BITS'(cfir_pkg::TAPS) - cfir_pkg::COEF_BITS'(tap);
      c_re    = $signed({1'b0, coef_re});
      c_im    = $signed({1'b0, coef_im});
      // entries never written since reset count as zero
      x_re    = ctl.live ? hist_real : '0;
      x_im    = ctl.live ? hist_imag : '0;
      p_rr_in = cfir_pkg::PROD_BITS'(x_re) * cfir_pkg::PROD_BITS'(c_re);
      p_ii_in = cfir_pkg::PROD_BITS'(x_im) * cfir_pkg::PROD_BITS'(c_im);
      p_ri_in = cfir_pkg::PROD_BITS'(x_re) * cfir_pkg::PROD_BITS'(c_im);
      p_ir_in = cfir_pkg::PROD_BITS'(x_im) * cfir_pkg::PROD_BITS'(c_re);
   end

   always_ff @(posedge clock) begin
      p_rr_ff   <= p_rr_in;
      p_ii_ff   <= p_ii_in;
      p_ri_ff   <= p_ri_in;
      p_ir_ff   <= p_ir_in;
      p_last_ff <= ctl.last;
   end

   always_comb begin
      acc_real_in = acc_real_ff + cfir_pkg::RESULT_BITS'(p_rr_ff)
                    - cfir_pkg::RESULT_BITS'(p_ii_ff);
      acc_imag_in = acc_imag_ff + cfir_pkg::RESULT_BITS'(p_ri_ff)
                    + cfir_pkg::RESULT_BITS'(p_ir_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         p_vld_ff <= ctl.vld;
         done_ff  <= p_vld_ff & p_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_real_ff <= '0;
         acc_imag_ff <= '0;
      end else if (p_vld_ff) begin
         acc_real_ff <= acc_real_in;
         acc_imag_ff <= acc_imag_in;
      end
   end

   assign acc_real = acc_real_ff;
   assign acc_imag = acc_imag_ff;
   assign done     = done_ff;

endmodule

@@ src/complex_fir_filter_unit.sv @@
`timescale 1ns / 1ps

// complex fir filter, direct form, 25 fixed complex taps
// input channel req_: one complex sample word (req_sample_real, req_sample_imag),
//    taken when req_valid and req_ready are both high
// result channel rsp_: one complex result word per sample
//    (rsp_result_real, rsp_result_imag), exact 26-bit sums, taken on
//    rsp_valid and rsp_ready
// taps: real tap k is k+1, imaginary tap k is 25-k, k=0 for the newest sample
// the delay line sits in one 25-entry memory used as a ring; the accept cycle
//    writes the new sample, then one entry is read per cycle and fed through a
//    registered complex multiply and an accumulator
// one sample in flight: a new sample is taken only after the last one has walked
//    the 25 taps through the single memory read port and passed the multiply and
//    accumulate stages
// req_ready is high only between words; it does not wait for the result
//    register, so a new sample is taken while the last result still waits
// if the receiver stalls, the finished sum is held in the accumulator until
//    the result register frees up, and the next word waits with it
// reset (synchronous, active high) empties the delay line by clearing the
//    fill count: entries not yet written read as zero, no clearing pass

module complex_fir_filter_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [cfir_pkg::SAMPLE_BITS-1:0]  req_sample_real,
   input  logic signed [cfir_pkg::SAMPLE_BITS-1:0]  req_sample_imag,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [cfir_pkg::RESULT_BITS-1:0]  rsp_result_real,
   output logic signed [cfir_pkg::RESULT_BITS-1:0]  rsp_result_imag
);

   // delay line memory, one complex sample per entry, imag in the high half
   logic [cfir_pkg::WORD_BITS-1:0] hist_mem [cfir_pkg::TAPS];
   logic [cfir_pkg::WORD_BITS-1:0] rd_data_ff;

   cfir_pkg::state_type            state_ff, state_in;
   logic [cfir_pkg::IDX_BITS-1:0]  head_ff, head_in;     // newest entry
   logic [cfir_pkg::IDX_BITS-1:0]  rd_ptr_ff, rd_ptr_in; // entry being read
   logic [cfir_pkg::IDX_BITS-1:0]  tap_ff, tap_in;       // age of that entry
   logic [cfir_pkg::CNT_BITS-1:0]  fill_ff, fill_in;     // samples since reset, saturates at TAPS

   // read stage, lines up with rd_data_ff
   logic                           s1_vld_ff, s1_live_ff, s1_last_ff;
   logic [cfir_pkg::IDX_BITS-1:0]  s1_tap_ff;

   logic                           accept;
   logic                           issue;
   logic                           load_out;
   logic                           out_free;
   logic                           rsp_valid_ff;
   logic signed [cfir_pkg::RESULT_BITS-1:0] rsp_real_ff, rsp_imag_ff;

   cfir_pkg::mac_ctl_type          mac_ctl;
   logic signed [cfir_pkg::RESULT_BITS-1:0] acc_real, acc_imag;
   logic                           mac_done;

   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign accept   = req_valid & req_ready;

   // control: next state and handshake
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      rd_ptr_in = rd_ptr_ff;
      tap_in    = tap_ff;
      fill_in   = fill_ff;
      req_ready = 1'b0;
      issue     = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         cfir_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // advance the ring head, new sample lands there
               if (head_ff == cfir_pkg::IDX_BITS'(cfir_pkg::TAPS - 1)) begin
                  head_in = '0;
               end else begin
                  head_in = head_ff + cfir_pkg::IDX_BITS'(1);
               end
               rd_ptr_in = head_in;
               tap_in    = '0;
               if (fill_ff != cfir_pkg::CNT_BITS'(cfir_pkg::TAPS)) begin
                  fill_in = fill_ff + cfir_pkg::CNT_BITS'(1);
               end
               state_in = cfir_pkg::ST_READ;
            end
         end
         cfir_pkg::ST_READ: begin
            issue = 1'b1;
            // walk backward from the newest sample
            if (rd_ptr_ff == '0) begin
               rd_ptr_in = cfir_pkg::IDX_BITS'(cfir_pkg::TAPS - 1);
            end else begin
               rd_ptr_in = rd_ptr_ff - cfir_pkg::IDX_BITS'(1);
            end
            if (tap_ff == cfir_pkg::IDX_BITS'(cfir_pkg::TAPS - 1)) begin
               state_in = cfir_pkg::ST_DRAIN;
            end else begin
               tap_in = tap_ff + cfir_pkg::IDX_BITS'(1);
            end
         end
         cfir_pkg::ST_DRAIN: begin
            // accumulator is final once the mac flags the last tap
            if (mac_done) begin
               if (out_free) begin
                  load_out = 1'b1;
                  state_in = cfir_pkg::ST_IDLE;
               end else begin
                  state_in = cfir_pkg::ST_OUT;
               end
            end
         end
         cfir_pkg::ST_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = cfir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfir_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cfir_pkg::ST_IDLE;
         head_ff   <= '0;
         rd_ptr_ff <= '0;
         tap_ff    <= '0;
         fill_ff   <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         rd_ptr_ff <= rd_ptr_in;
         tap_ff    <= tap_in;
         fill_ff   <= fill_in;
         s1_vld_ff <= issue;
      end
   end

   // memory: write on accept, registered read while walking taps
   // write and reads never share a cycle, so no forwarding is needed
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_mem[head_in] <= {req_sample_imag, req_sample_real};
      end
      rd_data_ff <= hist_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      s1_tap_ff  <= tap_ff;
      s1_live_ff <= cfir_pkg::CNT_BITS'(tap_ff) < fill_ff;
      s1_last_ff <= tap_ff == cfir_pkg::IDX_BITS'(cfir_pkg::TAPS - 1);
   end

   always_comb begin
      mac_ctl.clear = accept;
      mac_ctl.vld   = s1_vld_ff;
      mac_ctl.live  = s1_live_ff;
      mac_ctl.last  = s1_last_ff;
   end

   cfir_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .tap       (s1_tap_ff),
      .hist_real (rd_data_ff[cfir_pkg::SAMPLE_BITS-1:0]),
      .hist_imag (rd_data_ff[cfir_pkg::WORD_BITS-1:cfir_pkg::SAMPLE_BITS]),
      .acc_real  (acc_real),
      .acc_imag  (acc_imag),
      .done      (mac_done)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_real_ff <= acc_real;
         rsp_imag_ff <= acc_imag;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_real = rsp_real_ff;
   assign rsp_result_imag = rsp_imag_ff;

   // fill count saturates at the delay line depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cfir_pkg::CNT_BITS'(cfir_pkg::TAPS))
      else $error("fill count past delay line depth");

   // memory reads only come from the tap walk
   assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> $past(state_ff == cfir_pkg::ST_READ))
      else $error("read data valid outside tap walk");

   // the last tap finishes only while draining
   assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == cfir_pkg::ST_DRAIN)
      else $error("accumulator finished outside drain");

   // a result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      load_out |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten");

endmodule
